[design/acc_pkg.sv]
package acc_pkg;

  localparam int unsigned PollSources = 3;
  localparam logic [15:0] CheckIntervalReset = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_NIGHT  = 3'd1,
    ST_MANUAL = 3'd2,
    ST_LOW    = 3'd3,
    ST_DRAW   = 3'd4,
    ST_FEED   = 3'd5
  } state_e;

  typedef enum logic [3:0] {
    EV_NONE   = 4'd0,
    EV_FED    = 4'd1,
    EV_DIRTY  = 4'd2,
    EV_FILLED = 4'd3,
    EV_TIME   = 4'd4,
    EV_MIN    = 4'd5,
    EV_HUNGRY = 4'd6,
    EV_DRAW   = 4'd7,
    EV_FEED   = 4'd8,
    EV_LIGHTS = 4'd9
  } event_e;

  typedef enum logic [3:0] {
    A_NONE, A_DRAW_ON, A_DRAW_OFF, A_DAY, A_NIGHT, A_FEED_ON, A_FEED_OFF,
    A_TANK_OK, A_TANK_LOW, A_LIGHT_ON, A_LIGHT_OFF, A_LIGHT_TOGGLE
  } act_e;

  localparam logic [1:0] SLOT_WATER = 2'd0;
  localparam logic [1:0] SLOT_TIME  = 2'd1;
  localparam logic [1:0] SLOT_CMD   = 2'd2;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        water_low;
    logic        water_high;
    logic        night;
    logic        cmd_valid;
    logic [3:0]  cmd_event;
  } in_item_t;

  typedef struct packed {
    logic [2:0] fsm_state;
    logic       state_reported;
    logic       pump_drive;
    logic       feeder_drive;
    logic       lights_drive;
    logic       cmd_taken;
    logic [3:0] event_applied;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        idle_manual;
    logic        lights_flag;
    logic [31:0] last_poll;
    logic [1:0]  poll_slot;
    logic        pump;
    logic        feeder;
    logic        lamp;
  } ctl_state_t;

  function automatic act_e act_lookup(logic [2:0] mode, logic [3:0] ev);
    act_e a;
    a = A_NONE;
    case (ev)
      EV_FED: begin
        if (mode == ST_FEED) a = A_FEED_OFF;
      end
      EV_DIRTY: begin
        if (mode == ST_IDLE || mode == ST_MANUAL) a = A_DRAW_ON;
      end
      EV_FILLED: begin
        if (mode == ST_LOW) a = A_TANK_OK;
      end
      EV_TIME: begin
        if (mode == ST_IDLE || mode == ST_MANUAL) a = A_NIGHT;
        else if (mode == ST_NIGHT) a = A_DAY;
      end
      EV_MIN: begin
        if (mode == ST_DRAW) a = A_DRAW_OFF;
        else if (mode <= ST_FEED) a = A_TANK_LOW;
      end
      EV_HUNGRY: begin
        if (mode == ST_IDLE || mode == ST_MANUAL) a = A_FEED_ON;
      end
      EV_DRAW: begin
        if (mode <= ST_FEED) a = A_DRAW_ON;
      end
      EV_FEED: begin
        if (mode <= ST_FEED) a = A_FEED_ON;
      end
      EV_LIGHTS: begin
        if (mode == ST_IDLE) a = A_LIGHT_ON;
        else if (mode == ST_NIGHT || mode == ST_MANUAL) a = A_LIGHT_OFF;
        else if (mode <= ST_FEED) a = A_LIGHT_TOGGLE;
      end
      default: a = A_NONE;
    endcase
    return a;
  endfunction

endpackage

[design/aquarium_care_controller_fsm.sv]
// Aquarium care controller: one control-loop pass per input transfer.
// Input channel: in_valid_i / in_stall_o carry one in_item_t (timestamp,
// water and night sensors, optional remote command). Output channel:
// out_valid_o / out_stall_i carry one out_item_t per pass (state, drives,
// command consumed, event applied).
// Configuration: cfg_we_i writes cfg_wdata_i into the poll interval; write
// only while no pass is in flight.
// The result of a pass is registered, in the skid register under a stall.
// Throughput: one pass per cycle unless stalled; the next-state logic reads
// the state registers directly, so a pass can follow in the very next cycle.
// Reset: idle state, lights, pump and feeder off, poll turn on water, last
// poll time zero, interval 1000 ms; both channels empty.
// Stall: a result held by the receiver sits in the output register; one
// more pass is accepted into a skid register, after which in_stall_o rises
// until the output drains.
module aquarium_care_controller_fsm
  import acc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  ctl_state_t  st_q, st_d;
  logic [15:0] interval_q;
  out_item_t   res;
  out_item_t   out_q, skid_q;
  logic        out_valid_q, skid_valid_q;
  logic        in_fire, out_free;

  acc_step u_step (
    .st_i       (st_q),
    .interval_i (interval_q),
    .item_i     (in_data_i),
    .st_o       (st_d),
    .res_o      (res)
  );

  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= '0;
      interval_q   <= CheckIntervalReset;
      out_q        <= '0;
      skid_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) interval_q <= cfg_wdata_i;
      if (in_fire) st_q <= st_d;
      if (out_free) begin
        if (skid_valid_q) begin
          out_q        <= skid_q;
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_q       <= res;
          out_valid_q <= in_fire;
        end
      end else if (in_fire) begin
        skid_q       <= res;
        skid_valid_q <= 1'b1;
      end
    end
  end

endmodule

[design/acc_step.sv]
module acc_step
  import acc_pkg::*;
(
  input  ctl_state_t st_i,
  input  logic [15:0] interval_i,
  input  in_item_t   item_i,
  output ctl_state_t st_o,
  output out_item_t  res_o
);

  logic [31:0] elapsed;
  logic [3:0]  ev;
  logic        taken;
  logic        announced;
  logic        light_on;
  logic        light_off;
  logic [2:0]  idle_ret;
  act_e        act;

  function automatic logic [3:0] water_ev(logic [2:0] mode, logic low, logic high);
    logic [3:0] e;
    e = EV_NONE;
    if (low && mode != ST_LOW) e = EV_MIN;
    else if (high && mode == ST_LOW) e = EV_FILLED;
    return e;
  endfunction

  assign elapsed  = item_i.now_ms - st_i.last_poll;
  assign idle_ret = st_i.idle_manual ? ST_MANUAL : ST_IDLE;

  always_comb begin
    ev    = EV_NONE;
    taken = 1'b0;
    st_o  = st_i;
    if (elapsed > {16'd0, interval_i}) begin
      if (st_i.mode == ST_DRAW) begin
        ev = water_ev(st_i.mode, item_i.water_low, item_i.water_high);
      end else begin
        st_o.last_poll = item_i.now_ms;
        if (st_i.poll_slot == 2'(PollSources - 1)) st_o.poll_slot = SLOT_WATER;
        else if (st_i.poll_slot == 2'(PollSources)) st_o.poll_slot = SLOT_TIME;
        else st_o.poll_slot = st_i.poll_slot + 2'd1;
        case (st_i.poll_slot)
          SLOT_WATER: begin
            ev = water_ev(st_i.mode, item_i.water_low, item_i.water_high);
          end
          SLOT_TIME: begin
            if ((item_i.night && st_i.mode == ST_IDLE) ||
                (!item_i.night && st_i.mode == ST_NIGHT)) ev = EV_TIME;
          end
          default: begin
            if (item_i.cmd_valid) begin
              taken = 1'b1;
              ev    = (item_i.cmd_event <= EV_LIGHTS) ? item_i.cmd_event : EV_NONE;
            end
          end
        endcase
      end
    end

    act       = act_lookup(st_i.mode, ev);
    announced = 1'b0;
    light_on  = 1'b0;
    light_off = 1'b0;
    case (act)
      A_DRAW_ON: begin
        st_o.pump = 1'b1; st_o.mode = ST_DRAW; announced = 1'b1;
      end
      A_DRAW_OFF: begin
        st_o.pump = 1'b0; st_o.mode = ST_IDLE; announced = 1'b1;
      end
      A_DAY: begin
        st_o.lamp = 1'b0; st_o.mode = idle_ret; announced = 1'b1;
      end
      A_NIGHT: begin
        st_o.lamp = 1'b1; st_o.mode = ST_NIGHT; announced = 1'b1;
      end
      A_FEED_ON: begin
        st_o.feeder = 1'b1; st_o.mode = ST_FEED; announced = 1'b1;
      end
      A_FEED_OFF: begin
        st_o.feeder = 1'b0; st_o.mode = idle_ret; announced = 1'b1;
      end
      A_TANK_OK: begin
        st_o.mode = idle_ret; announced = 1'b1;
      end
      A_TANK_LOW: begin
        st_o.mode = ST_LOW; announced = 1'b1;
      end
      A_LIGHT_ON:     light_on = 1'b1;
      A_LIGHT_OFF:    light_off = 1'b1;
      A_LIGHT_TOGGLE: begin
        if (st_i.lights_flag) light_off = 1'b1;
        else light_on = 1'b1;
      end
      default: ;
    endcase

    if (light_on) begin
      st_o.lamp        = 1'b1;
      st_o.lights_flag = 1'b1;
      st_o.idle_manual = 1'b1;
      if (st_i.mode == ST_IDLE) begin
        st_o.mode = ST_MANUAL; announced = 1'b1;
      end
    end
    if (light_off) begin
      st_o.lamp        = 1'b0;
      st_o.lights_flag = 1'b0;
      st_o.idle_manual = 1'b0;
      if (st_i.mode == ST_MANUAL) begin
        st_o.mode = ST_IDLE; announced = 1'b1;
      end
    end

    res_o.fsm_state      = st_o.mode;
    res_o.state_reported = announced;
    res_o.pump_drive     = st_o.pump;
    res_o.feeder_drive   = st_o.feeder;
    res_o.lights_drive   = st_o.lamp;
    res_o.cmd_taken      = taken;
    res_o.event_applied  = ev;
  end

endmodule

[sim/tb_aquarium_care_controller_fsm.sv]
module tb_aquarium_care_controller_fsm;
  timeunit 1ns;
  timeprecision 1ps;

  import acc_pkg::*;

  localparam time HalfPeriod = 4ns;
  localparam int HoldCycles = 64;
  localparam int QuietLimit = 4000;
  localparam logic [3:0] BadCode = 4'hF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  aquarium_care_controller_fsm dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // controller state as the design should hold it
  state_e      mode = ST_IDLE;
  state_e      idle_ret = ST_IDLE;
  logic        lights_flag = 1'b0;
  logic        pump = 1'b0;
  logic        feeder = 1'b0;
  logic        lamp = 1'b0;
  logic        announced = 1'b0;
  logic [31:0] last_poll = '0;
  logic [1:0]  poll_slot = SLOT_WATER;
  logic [15:0] ivl = CheckIntervalReset;

  out_item_t   awaited_passes[$];
  in_item_t    row_in[$];
  logic        row_chk[$];
  out_item_t   row_want[$];

  logic [31:0] stamp = '0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          press_req = 0;
  int          press_seen = 0;
  int          hold_left = 0;
  int          errors = 0;
  int          n_passes = 0;
  int          n_checked = 0;
  int          n_taken = 0;
  int          n_reports = 0;
  int          n_intervals = 1;
  logic [7:0]  states_seen = '0;

  function automatic act_e route(state_e m, event_e e);
    act_e a = A_NONE;
    if (e == EV_DRAW) return A_DRAW_ON;
    if (e == EV_FEED) return A_FEED_ON;
    case (m)
      ST_IDLE, ST_MANUAL: begin
        case (e)
          EV_DIRTY:  a = A_DRAW_ON;
          EV_TIME:   a = A_NIGHT;
          EV_MIN:    a = A_TANK_LOW;
          EV_HUNGRY: a = A_FEED_ON;
          EV_LIGHTS: a = (m == ST_IDLE) ? A_LIGHT_ON : A_LIGHT_OFF;
          default:   a = A_NONE;
        endcase
      end
      ST_NIGHT: begin
        if (e == EV_TIME) a = A_DAY;
        else if (e == EV_MIN) a = A_TANK_LOW;
        else if (e == EV_LIGHTS) a = A_LIGHT_OFF;
      end
      ST_LOW: begin
        if (e == EV_FILLED) a = A_TANK_OK;
        else if (e == EV_MIN) a = A_TANK_LOW;
        else if (e == EV_LIGHTS) a = A_LIGHT_TOGGLE;
      end
      ST_DRAW: begin
        if (e == EV_MIN) a = A_DRAW_OFF;
        else if (e == EV_LIGHTS) a = A_LIGHT_TOGGLE;
      end
      ST_FEED: begin
        if (e == EV_FED) a = A_FEED_OFF;
        else if (e == EV_MIN) a = A_TANK_LOW;
        else if (e == EV_LIGHTS) a = A_LIGHT_TOGGLE;
      end
      default: a = A_NONE;
    endcase
    return a;
  endfunction

  function automatic event_e water_ev(in_item_t it);
    if (it.water_low && mode != ST_LOW) return EV_MIN;
    if (it.water_high && mode == ST_LOW) return EV_FILLED;
    return EV_NONE;
  endfunction

  task automatic enter(state_e s);
    mode = s;
    announced = 1'b1;
  endtask

  task automatic lights_set(logic on);
    lamp = on;
    lights_flag = on;
    idle_ret = on ? ST_MANUAL : ST_IDLE;
    if (on && mode == ST_IDLE) enter(ST_MANUAL);
    if (!on && mode == ST_MANUAL) enter(ST_IDLE);
  endtask

  task automatic care_pass(input in_item_t it, output out_item_t r);
    event_e     ev;
    logic       took;
    logic [1:0] slot;
    ev = EV_NONE;
    took = 1'b0;
    announced = 1'b0;
    if (it.now_ms - last_poll > {16'd0, ivl}) begin
      if (mode == ST_DRAW) begin
        ev = water_ev(it);
      end else begin
        slot = poll_slot;
        last_poll = it.now_ms;
        poll_slot = (slot == SLOT_CMD) ? SLOT_WATER : slot + 2'd1;
        if (slot == SLOT_WATER) begin
          ev = water_ev(it);
        end else if (slot == SLOT_TIME) begin
          if ((it.night && mode == ST_IDLE) || (!it.night && mode == ST_NIGHT)) ev = EV_TIME;
        end else if (it.cmd_valid) begin
          took = 1'b1;
          if (it.cmd_event <= EV_LIGHTS) ev = event_e'(it.cmd_event);
        end
      end
    end
    case (route(mode, ev))
      A_DRAW_ON:      begin pump = 1'b1; enter(ST_DRAW); end
      A_DRAW_OFF:     begin pump = 1'b0; enter(ST_IDLE); end
      A_DAY:          begin lamp = 1'b0; enter(idle_ret); end
      A_NIGHT:        begin lamp = 1'b1; enter(ST_NIGHT); end
      A_FEED_ON:      begin feeder = 1'b1; enter(ST_FEED); end
      A_FEED_OFF:     begin feeder = 1'b0; enter(idle_ret); end
      A_TANK_OK:      enter(idle_ret);
      A_TANK_LOW:     enter(ST_LOW);
      A_LIGHT_ON:     lights_set(1'b1);
      A_LIGHT_OFF:    lights_set(1'b0);
      A_LIGHT_TOGGLE: lights_set(!lights_flag);
      default: ;
    endcase
    r.fsm_state = mode;
    r.state_reported = announced;
    r.pump_drive = pump;
    r.feeder_drive = feeder;
    r.lights_drive = lamp;
    r.cmd_taken = took;
    r.event_applied = ev;
    n_taken += int'(took);
    n_reports += int'(announced);
    states_seen[mode] = 1'b1;
  endtask

  function automatic in_item_t pass_in(logic [31:0] now, logic wl, logic wh, logic nt,
                                       logic cv, logic [3:0] code);
    in_item_t it;
    it.now_ms = now;
    it.water_low = wl;
    it.water_high = wh;
    it.night = nt;
    it.cmd_valid = cv;
    it.cmd_event = code;
    return it;
  endfunction

  function automatic out_item_t pass_out(state_e st, logic rep, logic pu, logic fe, logic li,
                                         logic tk, event_e ev);
    out_item_t r;
    r.fsm_state = st;
    r.state_reported = rep;
    r.pump_drive = pu;
    r.feeder_drive = fe;
    r.lights_drive = li;
    r.cmd_taken = tk;
    r.event_applied = ev;
    return r;
  endfunction

  task automatic add_row(in_item_t it, logic chk, out_item_t want);
    row_in.push_back(it);
    row_chk.push_back(chk);
    row_want.push_back(want);
  endtask

  function automatic in_item_t rand_pass();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 62) stamp = stamp + {16'd0, ivl} + 32'd1 + $urandom_range(0, 1500);
    else if (pick < 72) stamp = stamp + $urandom_range(0, {16'd0, ivl});
    else if (pick < 79) stamp = last_poll + {16'd0, ivl};
    else if (pick < 86) stamp = last_poll + {16'd0, ivl} + 32'd1;
    else if (pick < 93) stamp = stamp + $urandom;
    else stamp = $urandom;
    return pass_in(stamp, $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 40,
                   $urandom_range(0, 99) < 50, $urandom_range(0, 99) < 80,
                   ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 9))
                                                : 4'($urandom_range(0, 15)));
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (awaited_passes.size() == 0) begin
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      errors++;
    end else begin
      want = awaited_passes.pop_front();
      n_checked++;
      check_field("fsm_state", int'(want.fsm_state), int'(got.fsm_state));
      check_field("state_reported", int'(want.state_reported), int'(got.state_reported));
      check_field("pump_drive", int'(want.pump_drive), int'(got.pump_drive));
      check_field("feeder_drive", int'(want.feeder_drive), int'(got.feeder_drive));
      check_field("lights_drive", int'(want.lights_drive), int'(got.lights_drive));
      check_field("cmd_taken", int'(want.cmd_taken), int'(got.cmd_taken));
      check_field("event_applied", int'(want.event_applied), int'(got.event_applied));
    end
  endtask

  // hold the payload until the transfer
  task automatic offer(in_item_t it);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    n_passes++;
  endtask

  task automatic set_interval(logic [15:0] v);
    while (awaited_passes.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ivl = v;
    n_intervals++;
  endtask

  task automatic run_phase(logic [15:0] v, int gp, int sp, int count, logic press);
    in_item_t  it;
    out_item_t r;
    set_interval(v);
    gap_pct = gp;
    stall_pct = sp;
    if (press) press_req++;
    repeat (count) begin
      it = rand_pass();
      offer(it);
      care_pass(it, r);
      awaited_passes.push_back(r);
    end
    in_valid_i <= 1'b0;
  endtask

  // receiver: check each transfer, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
      if (press_seen != press_req) begin
        press_seen = press_req;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    int quiet = 0;
    @(posedge rst_ni);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    out_item_t r;
    add_row(pass_in(32'd0, 1'b1, 1'b0, 1'b0, 1'b0, EV_NONE), 1'b1,
            pass_out(ST_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE));
    add_row(pass_in(32'd1000, 1'b1, 1'b0, 1'b0, 1'b0, EV_NONE), 1'b1,
            pass_out(ST_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE));
    add_row(pass_in(32'd1001, 1'b1, 1'b0, 1'b0, 1'b0, EV_NONE), 1'b1,
            pass_out(ST_LOW, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EV_MIN));
    add_row(pass_in(32'd2002, 1'b0, 1'b0, 1'b1, 1'b0, EV_NONE), 1'b1,
            pass_out(ST_LOW, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE));
    add_row(pass_in(32'd3003, 1'b0, 1'b0, 1'b0, 1'b1, BadCode), 1'b1,
            pass_out(ST_LOW, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, EV_NONE));
    add_row(pass_in(32'd4004, 1'b0, 1'b1, 1'b0, 1'b0, EV_NONE), 1'b1,
            pass_out(ST_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EV_FILLED));
    add_row(pass_in(32'd5005, 1'b0, 1'b0, 1'b1, 1'b0, EV_NONE), 1'b1,
            pass_out(ST_NIGHT, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, EV_TIME));
    add_row(pass_in(32'd6006, 1'b0, 1'b0, 1'b1, 1'b1, EV_NONE), 1'b1,
            pass_out(ST_NIGHT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, EV_NONE));
    add_row(pass_in(32'd7007, 1'b0, 1'b0, 1'b1, 1'b0, EV_NONE), 1'b1,
            pass_out(ST_NIGHT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, EV_NONE));
    add_row(pass_in(32'd8008, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE), 1'b1,
            pass_out(ST_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, EV_TIME));
    add_row(pass_in(32'd9009, 1'b0, 1'b0, 1'b0, 1'b0, EV_LIGHTS), 1'b1,
            pass_out(ST_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE));
    add_row(pass_in(32'd10010, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE), 1'b0, '0);
    add_row(pass_in(32'd11011, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE), 1'b0, '0);
    add_row(pass_in(32'd12012, 1'b0, 1'b0, 1'b0, 1'b1, EV_LIGHTS), 1'b0, '0);
    add_row(pass_in(32'd13013, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE), 1'b0, '0);
    add_row(pass_in(32'd14014, 1'b0, 1'b0, 1'b1, 1'b0, EV_NONE), 1'b0, '0);
    add_row(pass_in(32'd15015, 1'b0, 1'b0, 1'b0, 1'b1, EV_HUNGRY), 1'b0, '0);
    add_row(pass_in(32'd16016, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE), 1'b0, '0);
    add_row(pass_in(32'd17017, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE), 1'b0, '0);
    add_row(pass_in(32'd18018, 1'b0, 1'b0, 1'b0, 1'b1, EV_FED), 1'b0, '0);
    add_row(pass_in(32'd19019, 1'b1, 1'b0, 1'b0, 1'b0, EV_NONE), 1'b0, '0);
    add_row(pass_in(32'd20020, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE), 1'b0, '0);
    add_row(pass_in(32'd21021, 1'b0, 1'b0, 1'b0, 1'b1, EV_DRAW), 1'b0, '0);
    add_row(pass_in(32'd21500, 1'b1, 1'b0, 1'b0, 1'b0, EV_NONE), 1'b0, '0);
    add_row(pass_in(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, BadCode), 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 23;
    stall_pct = 78;
    foreach (row_in[i]) begin
      offer(row_in[i]);
      care_pass(row_in[i], r);
      awaited_passes.push_back(row_chk[i] ? row_want[i] : r);
    end
    stamp = 32'hFFFF_FFFF;
    in_valid_i <= 1'b0;

    run_phase(16'd0, 23, 78, 80, 1'b0);
    run_phase(16'hFFFF, 78, 23, 70, 1'b0);
    run_phase(16'($urandom_range(1, 5000)), 78, 23, 80, 1'b0);
    run_phase(16'd1, 0, 0, 70, 1'b1);
    run_phase(16'($urandom_range(0, 65535)), 0, 0, 80, 1'b0);

    while (awaited_passes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d passes sent, %0d results checked, %0d poll interval settings incl. 0 and 65535",
             n_passes, n_checked, n_intervals);
    $display("%0d commands taken, %0d state changes announced, states reached %b",
             n_taken, n_reports, states_seen[5:0]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/acc_pkg.sv
design/acc_step.sv
design/aquarium_care_controller_fsm.sv
sim/tb_aquarium_care_controller_fsm.sv
